// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled in reset.
`define CHK_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that is also active during reset.
`define CHK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- sv/fsm_pkg.sv -----
// Package for the Forth stack machine step core: opcodes, states, control structs.
// No dependencies.
package fsm_pkg;
    localparam int CELL_BITS_DEF    = 32;
    localparam int MEM_WORDS_DEF    = 4096;
    localparam int DATA_DEPTH_DEF   = 32;
    localparam int RETURN_DEPTH_DEF = 32;
    localparam int ADDR_W = 12;

    localparam logic [4:0] OP_COLON = 5'd1;
    localparam logic [4:0] OP_SEMI  = 5'd2;
    localparam logic [4:0] OP_LIT   = 5'd3;
    localparam logic [4:0] OP_CONST = 5'd4;
    localparam logic [4:0] OP_VAR   = 5'd5;
    localparam logic [4:0] OP_ROT   = 5'd8;
    localparam logic [4:0] OP_DROP  = 5'd9;
    localparam logic [4:0] OP_DUP   = 5'd10;
    localparam logic [4:0] OP_SWAP  = 5'd11;
    localparam logic [4:0] OP_PLUS  = 5'd12;
    localparam logic [4:0] OP_EQ    = 5'd13;
    localparam logic [4:0] OP_FETCH = 5'd14;
    localparam logic [4:0] OP_STORE = 5'd15;
    localparam logic [4:0] OP_ZBR   = 5'd16;
    localparam logic [4:0] OP_BR    = 5'd17;
    localparam logic [4:0] OP_EXEC  = 5'd18;
    localparam logic [4:0] OP_COUNT = 5'd20;
    localparam logic [4:0] OP_EMIT  = 5'd24;

    localparam logic [1:0] FLT_OK    = 2'd0;
    localparam logic [1:0] FLT_DUNDER = 2'd1;
    localparam logic [1:0] FLT_DOVER = 2'd2;
    localparam logic [1:0] FLT_RET   = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_EXEC, ST_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clear_en;   // write zero at the sweep address
        logic load;       // capture the input item and read operands
        logic exec;       // apply the item to the state
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic clear_last;
    } t_stat;
endpackage

// ----- sv/fsm_ctrl.sv -----
// Controller of the Forth stack machine step core.
// Depends on fsm_pkg.
module fsm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  fsm_pkg::t_stat i_stat,
    output fsm_pkg::t_cmd  o_cmd
);
    fsm_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsm_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state. In DONE the next item is loaded as the result is taken; a stalled result stalls input.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fsm_pkg::ST_CLEAR: if (i_stat.clear_last) n_state = fsm_pkg::ST_IDLE;
            fsm_pkg::ST_IDLE:  if (i_in_valid) n_state = fsm_pkg::ST_EXEC;
            fsm_pkg::ST_EXEC:  n_state = fsm_pkg::ST_DONE;
            fsm_pkg::ST_DONE: begin
                if (!i_out_stall) begin
                    n_state = i_in_valid ? fsm_pkg::ST_EXEC : fsm_pkg::ST_IDLE;
                end
            end
            default: n_state = fsm_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            fsm_pkg::ST_CLEAR: o_cmd.clear_en = 1'b1;
            fsm_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            fsm_pkg::ST_EXEC: o_cmd.exec = 1'b1;
            fsm_pkg::ST_DONE: begin
                o_out_valid    = 1'b1;
                o_in_stall     = i_out_stall;
                o_cmd.load     = !i_out_stall && i_in_valid;
            end
            default: o_cmd = '0;
        endcase
    end
endmodule

// ----- sv/fsm_dp.sv -----
// Datapath of the Forth stack machine step core: stacks, cell memory, result register.
// Depends on fsm_pkg.
module fsm_dp #(
    parameter int CELL_BITS    = fsm_pkg::CELL_BITS_DEF,
    parameter int MEM_WORDS    = fsm_pkg::MEM_WORDS_DEF,
    parameter int DATA_DEPTH   = fsm_pkg::DATA_DEPTH_DEF,
    parameter int RETURN_DEPTH = fsm_pkg::RETURN_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fsm_pkg::t_cmd             i_cmd,
    output fsm_pkg::t_stat            o_stat,
    input  logic [4:0]                i_opcode,
    input  logic signed [31:0]        i_operand,
    input  logic [fsm_pkg::ADDR_W-1:0] i_next_address,
    output logic [fsm_pkg::ADDR_W-1:0] o_new_address,
    output logic                      o_emit_valid,
    output logic [7:0]                o_emit_char,
    output logic [1:0]                o_fault
);
    localparam int MW = $clog2(MEM_WORDS);
    localparam int DW = $clog2(DATA_DEPTH);
    localparam int RW = $clog2(RETURN_DEPTH);
    localparam int AW = fsm_pkg::ADDR_W;

    logic [CELL_BITS-1:0] r_dstk [DATA_DEPTH];
    logic [AW-1:0]        r_rstk [RETURN_DEPTH];
    logic [CELL_BITS-1:0] r_mem  [MEM_WORDS];
    logic [DW:0]          r_dd;
    logic [RW:0]          r_rd;
    logic [MW-1:0]        r_clr;

    logic [4:0]           r_op;
    logic [CELL_BITS-1:0] r_opnd;
    logic [AW-1:0]        r_next;
    logic [CELL_BITS-1:0] r_t0, r_t1, r_t2, r_mrd;
    logic [AW-1:0]        r_rtop;

    logic [AW-1:0] r_naddr;
    logic          r_ev;
    logic [7:0]    r_ec;
    logic [1:0]    r_flt;

    // Sweep address and last-entry flag for the clearing pass.
    assign o_stat.clear_last = (r_clr == MW'(MEM_WORDS - 1));

    // Operand reads from the current stacks at load time.
    logic [DW-1:0] ld_i0, ld_i1, ld_i2;
    logic [RW-1:0] ld_ri;
    logic [CELL_BITS-1:0] ld_opnd;
    logic [MW-1:0] ld_maddr;
    always_comb begin
        ld_i0 = DW'(r_dd - 1'b1);
        ld_i1 = DW'(r_dd - 2'd2);
        ld_i2 = DW'(r_dd - 2'd3);
        ld_ri = RW'(r_rd - 1'b1);
        ld_opnd = CELL_BITS'(i_operand);
        if ((i_opcode == fsm_pkg::OP_CONST)) begin
            ld_maddr = MW'(i_next_address);
        end else begin
            ld_maddr = r_dstk[ld_i0][MW-1:0];
        end
    end

    // Item capture, stack reads and the registered memory read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_opnd <= ld_opnd;
            r_next <= i_next_address;
            r_t0   <= r_dstk[ld_i0];
            r_t1   <= r_dstk[ld_i1];
            r_t2   <= r_dstk[ld_i2];
            r_rtop <= r_rstk[ld_ri];
            r_mrd  <= r_mem[ld_maddr];
        end
    end

    // Fault checks and next state of the stacks.
    logic [DW:0] need_d, grow_d;
    logic        rpush, rpop;
    logic [1:0]  flt;
    always_comb begin
        need_d = '0;
        grow_d = '0;
        rpush  = 1'b0;
        rpop   = 1'b0;
        case (r_op)
            fsm_pkg::OP_COLON: rpush = 1'b1;
            fsm_pkg::OP_SEMI:  rpop = 1'b1;
            fsm_pkg::OP_LIT:   grow_d = (DW+1)'(1);
            fsm_pkg::OP_CONST, fsm_pkg::OP_VAR: begin
                grow_d = (DW+1)'(1);
                rpop   = 1'b1;
            end
            fsm_pkg::OP_ROT: need_d = (DW+1)'(3);
            fsm_pkg::OP_DROP, fsm_pkg::OP_FETCH, fsm_pkg::OP_ZBR,
            fsm_pkg::OP_EMIT: need_d = (DW+1)'(1);
            fsm_pkg::OP_DUP, fsm_pkg::OP_COUNT: begin
                need_d = (DW+1)'(1);
                grow_d = (DW+1)'(1);
            end
            fsm_pkg::OP_SWAP, fsm_pkg::OP_PLUS, fsm_pkg::OP_EQ,
            fsm_pkg::OP_STORE: need_d = (DW+1)'(2);
            fsm_pkg::OP_EXEC: begin
                need_d = (DW+1)'(1);
                rpush  = 1'b1;
            end
            default: need_d = '0;
        endcase
        if (r_dd < need_d) flt = fsm_pkg::FLT_DUNDER;
        else if ((r_dd + grow_d) > (DW+1)'(DATA_DEPTH)) flt = fsm_pkg::FLT_DOVER;
        else if (rpop && r_rd == '0) flt = fsm_pkg::FLT_RET;
        else if (rpush && r_rd >= (RW+1)'(RETURN_DEPTH)) flt = fsm_pkg::FLT_RET;
        else flt = fsm_pkg::FLT_OK;
    end

    // Writes decided from the captured operands.
    logic          we0, we1, we2, we_r, we_m;
    logic [DW-1:0] wi0, wi1, wi2;
    logic [CELL_BITS-1:0] wd0, wd1, wd2, wd_m;
    logic [MW-1:0] wa_m;
    logic [DW:0]   dd_n;
    logic [RW:0]   rd_n;
    logic [AW-1:0] naddr;
    logic          ev;
    logic [7:0]    ec;
    always_comb begin
        we0 = 1'b0; we1 = 1'b0; we2 = 1'b0; we_r = 1'b0; we_m = 1'b0;
        wi0 = DW'(r_dd);
        wi1 = DW'(r_dd - 1'b1);
        wi2 = DW'(r_dd - 2'd2);
        wd0 = '0; wd1 = '0; wd2 = '0;
        wd_m = r_t1;
        wa_m = r_t0[MW-1:0];
        dd_n = r_dd;
        rd_n = r_rd;
        naddr = r_next;
        ev = 1'b0;
        ec = '0;
        if (flt == fsm_pkg::FLT_OK) begin
            case (r_op)
                fsm_pkg::OP_COLON: begin
                    we_r = 1'b1;
                    rd_n = r_rd + 1'b1;
                    naddr = r_opnd[AW-1:0];
                end
                fsm_pkg::OP_SEMI: begin
                    rd_n = r_rd - 1'b1;
                    naddr = r_rtop;
                end
                fsm_pkg::OP_LIT: begin
                    we0 = 1'b1; wd0 = r_opnd; dd_n = r_dd + 1'b1;
                end
                fsm_pkg::OP_CONST: begin
                    we0 = 1'b1; wd0 = r_mrd; dd_n = r_dd + 1'b1;
                    rd_n = r_rd - 1'b1;
                end
                fsm_pkg::OP_VAR: begin
                    we0 = 1'b1; wd0 = CELL_BITS'(r_next); dd_n = r_dd + 1'b1;
                    rd_n = r_rd - 1'b1;
                end
                fsm_pkg::OP_ROT: begin
                    wi0 = DW'(r_dd - 1'b1); wd0 = r_t2; we0 = 1'b1;
                    wi1 = DW'(r_dd - 2'd2); wd1 = r_t0; we1 = 1'b1;
                    wi2 = DW'(r_dd - 2'd3); wd2 = r_t1; we2 = 1'b1;
                end
                fsm_pkg::OP_DROP: dd_n = r_dd - 1'b1;
                fsm_pkg::OP_DUP: begin
                    we0 = 1'b1; wd0 = r_t0; dd_n = r_dd + 1'b1;
                end
                fsm_pkg::OP_SWAP: begin
                    wi0 = DW'(r_dd - 1'b1); wd0 = r_t1; we0 = 1'b1;
                    wi1 = DW'(r_dd - 2'd2); wd1 = r_t0; we1 = 1'b1;
                end
                fsm_pkg::OP_PLUS: begin
                    wi0 = DW'(r_dd - 2'd2); wd0 = r_t0 + r_t1; we0 = 1'b1;
                    dd_n = r_dd - 1'b1;
                end
                fsm_pkg::OP_EQ: begin
                    wi0 = DW'(r_dd - 2'd2); we0 = 1'b1;
                    wd0 = CELL_BITS'(r_t0 == r_t1);
                    dd_n = r_dd - 1'b1;
                end
                fsm_pkg::OP_FETCH: begin
                    wi0 = DW'(r_dd - 1'b1); wd0 = r_mrd; we0 = 1'b1;
                end
                fsm_pkg::OP_STORE: begin
                    we_m = 1'b1;
                    dd_n = r_dd - 2'd2;
                end
                fsm_pkg::OP_ZBR: begin
                    dd_n = r_dd - 1'b1;
                    if (r_t0 == '0) naddr = r_opnd[AW-1:0];
                end
                fsm_pkg::OP_BR: naddr = r_opnd[AW-1:0];
                fsm_pkg::OP_EXEC: begin
                    we_r = 1'b1;
                    rd_n = r_rd + 1'b1;
                    dd_n = r_dd - 1'b1;
                    naddr = r_t0[AW-1:0];
                end
                fsm_pkg::OP_COUNT: begin
                    wi0 = DW'(r_dd - 1'b1); wd0 = r_t0 + 1'b1; we0 = 1'b1;
                    wi1 = DW'(r_dd); wd1 = CELL_BITS'(r_mrd[7:0]); we1 = 1'b1;
                    dd_n = r_dd + 1'b1;
                end
                fsm_pkg::OP_EMIT: begin
                    ev = 1'b1;
                    ec = r_t0[7:0];
                    dd_n = r_dd - 1'b1;
                end
                default: ev = 1'b0;
            endcase
        end
    end

    // Stack and memory updates, including the clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (we0) r_dstk[wi0] <= wd0;
            if (we1) r_dstk[wi1] <= wd1;
            if (we2) r_dstk[wi2] <= wd2;
            if (we_r) r_rstk[RW'(r_rd)] <= r_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.exec && we_m) begin
            r_mem[wa_m] <= wd_m;
        end
    end

    // Depths, sweep counter and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dd  <= '0;
            r_rd  <= '0;
            r_clr <= '0;
        end else begin
            if (i_cmd.clear_en) r_clr <= r_clr + 1'b1;
            if (i_cmd.exec) begin
                r_dd <= dd_n;
                r_rd <= rd_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_naddr <= naddr;
            r_ev    <= ev;
            r_ec    <= ec;
            r_flt   <= flt;
        end
    end

    assign o_new_address = r_naddr;
    assign o_emit_valid  = r_ev;
    assign o_emit_char   = r_ec;
    assign o_fault       = r_flt;
endmodule

// ----- sv/forth_stack_machine_step_core.sv -----
// Forth stack machine step core: one Forth primitive per input item.
// Each accepted item passes a load step, which reads the stacks and the cell
// memory port, and an execute step, which writes them back; the result is then
// held in DONE. No new item is taken during execution or while a result stalls.
// Reset: synchronous, active low; then a clearing pass zeroes the cell memory,
// one cell a cycle over all MEM_WORDS cells, while input stays stalled.
module forth_stack_machine_step_core #(
    parameter int CELL_BITS    = fsm_pkg::CELL_BITS_DEF,
    parameter int MEM_WORDS    = fsm_pkg::MEM_WORDS_DEF,
    parameter int DATA_DEPTH   = fsm_pkg::DATA_DEPTH_DEF,
    parameter int RETURN_DEPTH = fsm_pkg::RETURN_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [4:0]                 i_opcode,
    input  logic signed [31:0]         i_operand,
    input  logic [fsm_pkg::ADDR_W-1:0] i_next_address,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [fsm_pkg::ADDR_W-1:0] o_new_address,
    output logic                       o_emit_valid,
    output logic [7:0]                 o_emit_char,
    output logic [1:0]                 o_fault
);
    fsm_pkg::t_cmd  cmd;
    fsm_pkg::t_stat stat;

    fsm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .i_stat(stat), .o_cmd(cmd)
    );

    fsm_dp #(
        .CELL_BITS(CELL_BITS), .MEM_WORDS(MEM_WORDS),
        .DATA_DEPTH(DATA_DEPTH), .RETURN_DEPTH(RETURN_DEPTH)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_opcode, .i_operand, .i_next_address,
        .o_new_address, .o_emit_valid, .o_emit_char, .o_fault
    );
endmodule

// ----- sv/fsm_checker.sv -----
// Port-level checker for the Forth stack machine step core, with its bind.
// Depends on assert_macros.svh and fsm_pkg.
`include "assert_macros.svh"
module fsm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_emit_valid,
    input logic [7:0] o_emit_char,
    input logic [1:0] o_fault
);
    // No result during or right after reset.
    `CHK_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    // An accepted item yields a valid result once it has passed the EXEC state.
    `CHK_IMPL(a_lat, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> ##1 o_out_valid, "missing result")
    // A stalled result holds.
    `CHK_IMPL(a_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_fault), "result dropped")
    // A faulted item never emits.
    `CHK_IMPL(a_femit, i_clk, i_rst_n, (o_out_valid && o_fault != fsm_pkg::FLT_OK) |-> !o_emit_valid, "emit on fault")
endmodule

bind forth_stack_machine_step_core fsm_checker u_chk (.*);
